[rtl/core/nearest_centroid_word_histogram_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-centroid word histogram
// Shared property wrappers, sampled on clk_i and off while in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_WORD_HISTOGRAM_TOP_MACROS_SVH
`define NEAREST_CENTROID_WORD_HISTOGRAM_TOP_MACROS_SVH

// Immediate implication in the same cycle.
`define NCWH_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Implication in the next cycle.
`define NCWH_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/core/ncwh_pkg.sv]
// ----------------------------------------------------------------------------
// ncwh_pkg
// Types and constants shared by the histogram cells, top level and checker.
// ----------------------------------------------------------------------------
package ncwh_pkg;

  localparam int OpW     = 2;
  localparam int CentreW = 4;
  localparam int DimW    = 8;
  localparam int ValueW  = 16;
  localparam int BinW    = 4;
  localparam int CountW  = 16;
  localparam int SqW     = 2 * ValueW;
  localparam int SumW    = 40;

  localparam logic [OpW-1:0] OpLoad    = 2'd0;
  localparam logic [OpW-1:0] OpFeature = 2'd1;
  localparam logic [OpW-1:0] OpFinish  = 2'd2;

  localparam logic [SumW-1:0]   SumMax   = {SumW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SEARCH_GO,
    ST_SEARCH_WAIT,
    ST_EMIT
  } state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [CentreW-1:0]  centre;
    logic [ValueW-1:0]   value;
    logic                sum_clr;
    logic                shift;
    logic                inc_en;
  } cell_ctrl_t;

  // Running minimum handed down the chain.
  typedef struct packed {
    logic            valid;
    logic            found;
    logic [SumW-1:0] sum;
  } min_tok_t;

endpackage

[rtl/core/ncwh_cell.sv]
// ----------------------------------------------------------------------------
// ncwh_cell
// One centre: its element store, a three-stage squared-distance accumulator,
// one link of the minimum-search chain and one link of the count shift chain.
// ----------------------------------------------------------------------------
module ncwh_cell import ncwh_pkg::*; #(
  parameter int DIMS   = 250,
  parameter int ADDR_W = 8,
  parameter int IDX_W  = 4,
  parameter int IDX    = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [IDX_W-1:0]  inc_idx_i,
  input  min_tok_t          tok_i,
  input  logic [IDX_W-1:0]  tok_idx_i,
  output min_tok_t          tok_o,
  output logic [IDX_W-1:0]  tok_idx_o,
  input  logic [CountW-1:0] count_i,
  output logic [CountW-1:0] count_o
);

  logic [ValueW-1:0] mem [DIMS];

  logic [ValueW-1:0] elem_q;
  logic [ValueW-1:0] val_q;
  logic              a1_q;
  logic [SqW-1:0]    sq_q;
  logic              a2_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  min_tok_t          tok_q;
  logic [IDX_W-1:0]  tok_idx_q;

  logic              wr_hit;
  logic [ValueW-1:0] diff;
  logic [SumW:0]     sum_add;
  logic              take_own;
  logic              inc_hit;

  assign wr_hit   = ctrl_i.wr_en && (32'(ctrl_i.centre) == IDX);
  assign diff     = (val_q >= elem_q) ? (val_q - elem_q) : (elem_q - val_q);
  assign sum_add  = {1'b0, sum_q} + (SumW + 1)'(sq_q);
  assign take_own = !tok_i.found || (sum_q < tok_i.sum);
  assign inc_hit  = ctrl_i.inc_en && (inc_idx_i == IDX_W'(IDX));

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem[addr_i] <= ctrl_i.value;
    end
    if (ctrl_i.rd_en) begin
      elem_q <= mem[addr_i];
    end
  end

  // Payload stages of the distance pipeline.
  always_ff @(posedge clk_i) begin
    val_q <= ctrl_i.value;
    sq_q  <= SqW'(diff) * SqW'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q      <= 1'b0;
      a2_q      <= 1'b0;
      sum_q     <= '0;
      count_q   <= '0;
      tok_q     <= '0;
      tok_idx_q <= '0;
    end else begin
      a1_q <= ctrl_i.rd_en;
      a2_q <= a1_q;
      if (ctrl_i.sum_clr) begin
        sum_q <= '0;
      end else if (a2_q) begin
        sum_q <= sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
      end
      if (ctrl_i.shift) begin
        count_q <= count_i;
      end else if (inc_hit && (count_q != CountMax)) begin
        count_q <= count_q + 1'b1;
      end
      tok_q.valid <= tok_i.valid;
      tok_q.found <= 1'b1;
      if (take_own) begin
        tok_q.sum <= sum_q;
        tok_idx_q <= IDX_W'(IDX);
      end else begin
        tok_q.sum <= tok_i.sum;
        tok_idx_q <= tok_idx_i;
      end
    end
  end

  assign tok_o     = tok_q;
  assign tok_idx_o = tok_idx_q;
  assign count_o   = count_q;

endmodule

[rtl/core/nearest_centroid_word_histogram_top.sv]
// ----------------------------------------------------------------------------
// nearest_centroid_word_histogram_top
// Bag-of-words histogram over a chain of one cell per cluster centre.
// ----------------------------------------------------------------------------
// Items enter on start_i while busy_o is low; op_i picks load, feature or
// finish, op 3 is dropped. Load items write one centre element. In a
// feature item every cell reads its element, squares the difference and
// adds it to its sum over a three-stage pipe. Load items and feature items
// without end_of_descriptor_i leave busy_o low. A feature item with it set
// holds busy_o while the pipe drains in ST_DRAIN, a running minimum walks
// the cell chain one cell per cycle, then the winning cell bumps its count
// and all sums clear.
// A finish item holds busy_o through ST_DRAIN and ST_EMIT. Counts shift
// out of the chain toward cell 0, one per cycle; the first result is
// registered onto the ports from ST_EMIT and the rest follow back to back,
// each for one cycle with valid_o high, last_o on the final bin. The
// receiver cannot stall. Reset clears sums, counts and control; the centre
// store is not cleared and must be loaded before features arrive.
// ----------------------------------------------------------------------------
module nearest_centroid_word_histogram_top import ncwh_pkg::*; #(
  parameter int NUM_CENTRES = 16,
  parameter int DIMS        = 250
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [CentreW-1:0] centre_i,
  input  logic [DimW-1:0]    dim_i,
  input  logic [ValueW-1:0]  value_i,
  input  logic               end_of_descriptor_i,
  output logic               valid_o,
  output logic [BinW-1:0]    bin_o,
  output logic [CountW-1:0]  count_o,
  output logic               last_o
);

  localparam int AddrW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int IdxW  = $clog2(NUM_CENTRES);

  state_e            state_q, state_d;
  logic              drain_q, drain_d;
  logic              finish_q, finish_d;
  logic [IdxW-1:0]   emit_q, emit_d;
  logic              valid_q, valid_d;
  logic [BinW-1:0]   bin_q, bin_d;
  logic [CountW-1:0] count_q, count_d;
  logic              last_q, last_d;

  logic              accept;
  logic              dim_ok;
  logic [AddrW-1:0]  addr;
  logic [IdxW-1:0]   inc_idx;
  cell_ctrl_t        ctrl;

  min_tok_t          tok     [NUM_CENTRES+1];
  logic [IdxW-1:0]   tok_idx [NUM_CENTRES+1];
  logic [CountW-1:0] cnt     [NUM_CENTRES+1];

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign dim_ok = (32'(dim_i) < DIMS);
  assign addr   = AddrW'(dim_i);

  // Launch the minimum search into cell 0.
  assign tok[0].valid = (state_q == ST_SEARCH_GO);
  assign tok[0].found = 1'b0;
  assign tok[0].sum   = '0;
  assign tok_idx[0]   = '0;

  always_comb begin
    state_d      = state_q;
    drain_d      = drain_q;
    finish_d     = finish_q;
    emit_d       = emit_q;
    valid_d      = 1'b0;
    bin_d        = bin_q;
    count_d      = count_q;
    last_d       = last_q;
    inc_idx      = tok_idx[NUM_CENTRES];
    ctrl         = '0;
    ctrl.centre  = centre_i;
    ctrl.value   = value_i;
    ctrl.wr_en   = accept && (op_i == OpLoad) && dim_ok;
    ctrl.rd_en   = accept && (op_i == OpFeature) && dim_ok;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op_i == OpFeature) && end_of_descriptor_i) begin
          state_d  = ST_DRAIN;
          drain_d  = 1'b0;
          finish_d = 1'b0;
        end else if (accept && (op_i == OpFinish)) begin
          state_d  = ST_DRAIN;
          drain_d  = 1'b0;
          finish_d = 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait for the last accumulation to land in the sums
        drain_d = 1'b1;
        if (drain_q) begin
          emit_d  = '0;
          state_d = finish_q ? ST_EMIT : ST_SEARCH_GO;
        end
      end
      ST_SEARCH_GO: begin
        state_d = ST_SEARCH_WAIT;
      end
      ST_SEARCH_WAIT: begin
        if (tok[NUM_CENTRES].valid) begin
          ctrl.inc_en  = 1'b1;
          ctrl.sum_clr = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_EMIT: begin
        ctrl.shift   = 1'b1;
        ctrl.sum_clr = 1'b1;
        valid_d      = 1'b1;
        bin_d        = BinW'(emit_q);
        count_d      = cnt[0];
        last_d       = (emit_q == IdxW'(NUM_CENTRES - 1));
        emit_d       = emit_q + 1'b1;
        if (emit_q == IdxW'(NUM_CENTRES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      drain_q  <= 1'b0;
      finish_q <= 1'b0;
      emit_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      drain_q  <= drain_d;
      finish_q <= finish_d;
      emit_q   <= emit_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    count_q <= count_d;
    last_q  <= last_d;
  end

  assign cnt[NUM_CENTRES] = '0;

  for (genvar i = 0; i < NUM_CENTRES; i++) begin : g_cell
    ncwh_cell #(
      .DIMS   (DIMS),
      .ADDR_W (AddrW),
      .IDX_W  (IdxW),
      .IDX    (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .addr_i    (addr),
      .inc_idx_i (inc_idx),
      .tok_i     (tok[i]),
      .tok_idx_i (tok_idx[i]),
      .tok_o     (tok[i+1]),
      .tok_idx_o (tok_idx[i+1]),
      .count_i   (cnt[i+1]),
      .count_o   (cnt[i])
    );
  end

  assign valid_o = valid_q;
  assign bin_o   = bin_q;
  assign count_o = count_q;
  assign last_o  = last_q;

endmodule

[rtl/core/ncwh_checker.sv]
// ----------------------------------------------------------------------------
// ncwh_checker
// Port-level checks on the histogram burst and the busy handshake.
// ----------------------------------------------------------------------------
`include "nearest_centroid_word_histogram_top_macros.svh"

module ncwh_checker import ncwh_pkg::*; #(
  parameter int NUM_CENTRES = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [OpW-1:0]     op_i,
  input logic               valid_o,
  input logic [BinW-1:0]    bin_o,
  input logic               last_o
);

  `NCWH_ASSERT_NEXT(a_burst_contiguous, valid_o && !last_o, valid_o, "histogram burst broke off")
  `NCWH_ASSERT_NEXT(a_bin_advances, valid_o && !last_o, bin_o == $past(bin_o) + 1'b1, "bin skipped")
  `NCWH_ASSERT_SAME(a_last_bin, valid_o && last_o, bin_o == BinW'(NUM_CENTRES - 1), "wrong last bin")
  `NCWH_ASSERT_NEXT(a_finish_busy, start_i && !busy_o && (op_i == OpFinish), busy_o, "finish not held")

endmodule

bind nearest_centroid_word_histogram_top ncwh_checker #(
  .NUM_CENTRES (NUM_CENTRES)
) u_ncwh_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .op_i    (op_i),
  .valid_o (valid_o),
  .bin_o   (bin_o),
  .last_o  (last_o)
);
